FILE: hdl/abre_pkg.sv
package abre_pkg;

   // default coder widths
   localparam int PROB_BITS_DEF      = 12;
   localparam int RUN_COUNT_BITS_DEF = 32;

   // adaptation shift register
   localparam int                  SHIFT_W        = 4;
   localparam logic [SHIFT_W-1:0]  ADAPT_SHIFT_RST = 4'd5;
   localparam logic [SHIFT_W-1:0]  ADAPT_SHIFT_MIN = 4'd1;

   // coder state widths and limits
   localparam int                  LOW_W        = 33;
   localparam int                  RANGE_W      = 32;
   localparam logic [RANGE_W-1:0]  RANGE_RST    = 32'hFFFF_FFFF;
   localparam logic [RANGE_W-1:0]  RENORM_LIMIT = 32'h00FF_FFFF;
   localparam logic [RANGE_W-1:0]  CARRY_LIMIT  = 32'hFF00_0000;
   localparam logic [7:0]          FF_BYTE      = 8'hFF;

   // context tree
   localparam int                  NODE_W       = 8;
   localparam int                  TREE_DEPTH   = 256;
   localparam logic [NODE_W-1:0]   ROOT_NODE    = 8'd1;
   localparam logic [2:0]          LAST_BIT     = 3'd7;
   localparam logic [1:0]          LAST_LOW_BYTE = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MUL,
      ST_UPD,
      ST_REN_CHK,
      ST_REN_RUN,
      ST_FL_LEAD,
      ST_FL_RUN,
      ST_FL_LOW,
      ST_END
   } abre_state_type;

endpackage

FILE: hdl/abre_intf.sv
interface abre_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] sym;
   logic       last;

   modport source (output valid, output sym, output last, input ready);
   modport sink   (input valid, input sym, input last, output ready);
endinterface

interface abre_rsp_if #(
   parameter int RUN_COUNT_BITS = abre_pkg::RUN_COUNT_BITS_DEF
);
   logic                      valid;
   logic                      ready;
   logic [7:0]                out_byte;
   logic [RUN_COUNT_BITS-1:0] repeat_res;
   logic                      final_of_item;
   logic                      stream_end;

   modport source (output valid, output out_byte, output repeat_res,
                   output final_of_item, output stream_end, input ready);
   modport sink   (input valid, input out_byte, input repeat_res,
                   input final_of_item, input stream_end, output ready);
endinterface

interface abre_csr_if;
   logic                         valid;
   logic                         ready;
   logic [abre_pkg::SHIFT_W-1:0] adapt_shift;

   modport source (output valid, output adapt_shift, input ready);
   modport sink   (input valid, input adapt_shift, output ready);
endinterface

FILE: hdl/adaptive_binary_range_encoder.sv
// adaptive binary range encoder, one byte per request transfer, runs out as (byte, count)
// each coded bit steps through fetch, multiply, update and renorm check; each renorm shift repeats
//   the check, adding a run release state when it releases runs; an end state closes the byte
// a new request byte is taken only in idle, after the previous byte is fully coded
// reset: synchronous active high; coder state, tree valid bits and shift (to 5) restored,
//   a flush restores the same coder state but keeps the shift
module adaptive_binary_range_encoder #(
   parameter int PROB_BITS      = abre_pkg::PROB_BITS_DEF,
   parameter int RUN_COUNT_BITS = abre_pkg::RUN_COUNT_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   abre_req_if.sink      req_ch,
   abre_rsp_if.source    rsp_ch,
   abre_csr_if.sink      csr_ch
);

   localparam int                      MUL_A_W  = abre_pkg::RANGE_W - PROB_BITS;
   localparam logic [PROB_BITS:0]      SCALE    = {1'b1, {PROB_BITS{1'b0}}};
   localparam logic [PROB_BITS-1:0]    PROB_HALF = {1'b1, {(PROB_BITS-1){1'b0}}};
   localparam logic [RUN_COUNT_BITS-1:0] RUN_MAX = '1;
   localparam logic [RUN_COUNT_BITS-1:0] RUN_ONE = RUN_COUNT_BITS'(1);

   // sequencer
   abre_pkg::abre_state_type state_ff, state_in;

   // item registers
   logic [7:0]                         sym_ff, sym_in;
   logic                               last_ff, last_in;
   logic [abre_pkg::NODE_W-1:0]        node_ff, node_in;
   logic [2:0]                         bit_cnt_ff, bit_cnt_in;
   logic [1:0]                         fl_cnt_ff, fl_cnt_in;

   // coder state
   logic [abre_pkg::LOW_W-1:0]         low_ff, low_in;
   logic [abre_pkg::RANGE_W-1:0]       range_ff, range_in;
   logic [RUN_COUNT_BITS-1:0]          pcount_ff, pcount_in;
   logic [7:0]                         pbyte_ff, pbyte_in;
   logic [abre_pkg::RANGE_W-1:0]       mid_ff, mid_in;
   logic [abre_pkg::SHIFT_W-1:0]       shift_ff, shift_in;

   // probability tree ram with per-entry valid bits
   logic [PROB_BITS-1:0]               prob_mem [abre_pkg::TREE_DEPTH];
   logic [abre_pkg::TREE_DEPTH-1:0]    prob_vld_ff, prob_vld_in;
   logic [PROB_BITS-1:0]               prob_rd_ff;
   logic                               prob_rd_vld_ff;
   logic                               mem_we;
   logic [PROB_BITS-1:0]               mem_wdata;

   // held run (last one produced, waiting to learn if it ends the item)
   logic                               held_v_ff, held_v_in;
   logic [7:0]                         held_byte_ff, held_byte_in;
   logic [RUN_COUNT_BITS-1:0]          held_cnt_ff, held_cnt_in;

   // response register
   logic                               rsp_v_ff, rsp_v_in;
   logic [7:0]                         rsp_byte_ff, rsp_byte_in;
   logic [RUN_COUNT_BITS-1:0]          rsp_cnt_ff, rsp_cnt_in;
   logic                               rsp_final_ff, rsp_final_in;
   logic                               rsp_end_ff, rsp_end_in;

   // datapath
   logic [PROB_BITS-1:0]               p_cur;
   logic [MUL_A_W-1:0]                 mul_a;
   logic [abre_pkg::RANGE_W-1:0]       mid_calc;
   logic [abre_pkg::SHIFT_W-1:0]       shift_eff;
   logic [PROB_BITS:0]                 up_delta;
   logic [PROB_BITS-1:0]               dn_delta;
   logic [PROB_BITS-1:0]               p_one, p_zero;
   logic                               cur_bit;
   logic                               need_renorm, do_release, carry;
   logic [7:0]                         lead_byte, run_byte;
   logic [RUN_COUNT_BITS-1:0]          run_cnt, pcount_inc;
   logic [abre_pkg::LOW_W-1:0]         low_shl;
   logic [abre_pkg::RANGE_W-1:0]       range_shl;

   // run emission
   logic                               put_v, put_ok, out_free, end_ok, clear_state;
   logic [7:0]                         put_byte;
   logic [RUN_COUNT_BITS-1:0]          put_cnt;
   logic                               req_fire;

   assign req_ch.ready = (state_ff == abre_pkg::ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid         = rsp_v_ff;
   assign rsp_ch.out_byte      = rsp_byte_ff;
   assign rsp_ch.repeat_res    = rsp_cnt_ff;
   assign rsp_ch.final_of_item = rsp_final_ff;
   assign rsp_ch.stream_end    = rsp_end_ff;

   // shared arithmetic: probability, split point and adaptation
   assign p_cur     = prob_rd_vld_ff ? prob_rd_ff : PROB_HALF;
   assign mul_a     = range_ff[abre_pkg::RANGE_W-1:PROB_BITS];
   assign mid_calc  = abre_pkg::RANGE_W'(mul_a) * abre_pkg::RANGE_W'(p_cur);
   assign shift_eff = (shift_ff == '0) ? abre_pkg::ADAPT_SHIFT_MIN : shift_ff;
   assign up_delta  = (SCALE - {1'b0, p_cur}) >> shift_eff;
   assign dn_delta  = p_cur >> shift_eff;
   assign p_one     = p_cur + up_delta[PROB_BITS-1:0];
   assign p_zero    = p_cur - dn_delta;
   assign cur_bit   = sym_ff[7];

   // renormalization and carry handling
   assign need_renorm = (range_ff <= abre_pkg::RENORM_LIMIT);
   assign carry       = low_ff[abre_pkg::LOW_W-1];
   assign do_release  = (low_ff[abre_pkg::RANGE_W-1:0] < abre_pkg::CARRY_LIMIT) || carry;
   assign lead_byte   = pbyte_ff + {7'd0, carry};
   assign run_byte    = carry ? 8'h00 : abre_pkg::FF_BYTE;
   assign run_cnt     = pcount_ff - RUN_ONE;
   assign pcount_inc  = (pcount_ff != RUN_MAX) ? pcount_ff + RUN_ONE : pcount_ff;
   assign low_shl     = {1'b0, low_ff[23:0], 8'h00};
   assign range_shl   = {range_ff[23:0], 8'h00};

   // a new run may enter the holding slot if it is empty or the old one can move out
   assign out_free = !rsp_v_ff || rsp_ch.ready;
   assign put_ok   = !put_v || !held_v_ff || out_free;
   assign end_ok   = !held_v_ff || out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         abre_pkg::ST_IDLE: begin
            if (req_fire) state_in = abre_pkg::ST_FETCH;
         end
         abre_pkg::ST_FETCH: state_in = abre_pkg::ST_MUL;
         abre_pkg::ST_MUL:   state_in = abre_pkg::ST_UPD;
         abre_pkg::ST_UPD:   state_in = abre_pkg::ST_REN_CHK;
         abre_pkg::ST_REN_CHK: begin
            priority if (need_renorm) begin
               if (do_release && put_ok) state_in = abre_pkg::ST_REN_RUN;
            end else if (bit_cnt_ff != abre_pkg::LAST_BIT) begin
               state_in = abre_pkg::ST_FETCH;
            end else if (last_ff) begin
               state_in = abre_pkg::ST_FL_LEAD;
            end else begin
               state_in = abre_pkg::ST_END;
            end
         end
         abre_pkg::ST_REN_RUN: begin
            if (put_ok) state_in = abre_pkg::ST_REN_CHK;
         end
         abre_pkg::ST_FL_LEAD: begin
            if (put_ok) state_in = abre_pkg::ST_FL_RUN;
         end
         abre_pkg::ST_FL_RUN: begin
            if (put_ok) state_in = abre_pkg::ST_FL_LOW;
         end
         abre_pkg::ST_FL_LOW: begin
            if (put_ok && fl_cnt_ff == abre_pkg::LAST_LOW_BYTE) state_in = abre_pkg::ST_END;
         end
         abre_pkg::ST_END: begin
            if (end_ok) state_in = abre_pkg::ST_IDLE;
         end
         default: state_in = abre_pkg::ST_IDLE;
      endcase
   end

   // datapath and run emission
   always_comb begin
      sym_in      = sym_ff;
      last_in     = last_ff;
      node_in     = node_ff;
      bit_cnt_in  = bit_cnt_ff;
      fl_cnt_in   = fl_cnt_ff;
      low_in      = low_ff;
      range_in    = range_ff;
      pcount_in   = pcount_ff;
      pbyte_in    = pbyte_ff;
      mid_in      = mid_ff;
      mem_we      = 1'b0;
      mem_wdata   = p_zero;
      put_v       = 1'b0;
      put_byte    = lead_byte;
      put_cnt     = RUN_ONE;
      clear_state = 1'b0;

      unique case (state_ff)
         abre_pkg::ST_IDLE: begin
            if (req_fire) begin
               sym_in     = req_ch.sym;
               last_in    = req_ch.last;
               node_in    = abre_pkg::ROOT_NODE;
               bit_cnt_in = '0;
               fl_cnt_in  = '0;
            end
         end
         abre_pkg::ST_FETCH: begin
            // tree ram read of the current node is in flight
         end
         abre_pkg::ST_MUL: begin
            mid_in = mid_calc;
         end
         abre_pkg::ST_UPD: begin
            mem_we = 1'b1;
            if (cur_bit) begin
               range_in  = mid_ff;
               mem_wdata = p_one;
            end else begin
               low_in    = low_ff + abre_pkg::LOW_W'(mid_ff);
               range_in  = range_ff - mid_ff;
               mem_wdata = p_zero;
            end
            node_in = {node_ff[abre_pkg::NODE_W-2:0], cur_bit};
            sym_in  = {sym_ff[6:0], 1'b0};
         end
         abre_pkg::ST_REN_CHK: begin
            if (need_renorm) begin
               if (do_release) begin
                  // lead byte plus carry leaves first
                  put_v    = 1'b1;
                  put_byte = lead_byte;
                  put_cnt  = RUN_ONE;
               end else begin
                  // top byte is 0xff with no carry: it joins the pending run
                  pcount_in = pcount_inc;
                  low_in    = low_shl;
                  range_in  = range_shl;
               end
            end else if (bit_cnt_ff != abre_pkg::LAST_BIT) begin
               bit_cnt_in = bit_cnt_ff + 3'd1;
            end
         end
         abre_pkg::ST_REN_RUN: begin
            put_v    = (run_cnt != '0);
            put_byte = run_byte;
            put_cnt  = run_cnt;
            if (put_ok) begin
               pbyte_in  = low_ff[31:24];
               pcount_in = RUN_ONE;
               low_in    = low_shl;
               range_in  = range_shl;
            end
         end
         abre_pkg::ST_FL_LEAD: begin
            put_v    = 1'b1;
            put_byte = lead_byte;
            put_cnt  = RUN_ONE;
         end
         abre_pkg::ST_FL_RUN: begin
            put_v    = (run_cnt != '0);
            put_byte = run_byte;
            put_cnt  = run_cnt;
         end
         abre_pkg::ST_FL_LOW: begin
            put_v    = 1'b1;
            put_byte = low_ff[31:24];
            put_cnt  = RUN_ONE;
            if (put_ok) begin
               low_in    = low_shl;
               fl_cnt_in = fl_cnt_ff + 2'd1;
            end
         end
         abre_pkg::ST_END: begin
            clear_state = end_ok && last_ff;
         end
         default: begin
         end
      endcase

      if (clear_state) begin
         low_in    = '0;
         range_in  = abre_pkg::RANGE_RST;
         pcount_in = RUN_ONE;
         pbyte_in  = '0;
      end
   end

   // holding slot and response register
   always_comb begin
      held_v_in    = held_v_ff;
      held_byte_in = held_byte_ff;
      held_cnt_in  = held_cnt_ff;
      rsp_v_in     = rsp_v_ff && !rsp_ch.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_final_in = rsp_final_ff;
      rsp_end_in   = rsp_end_ff;

      if (put_v && put_ok) begin
         // older held run is not the last one of the item
         if (held_v_ff) begin
            rsp_v_in     = 1'b1;
            rsp_byte_in  = held_byte_ff;
            rsp_cnt_in   = held_cnt_ff;
            rsp_final_in = 1'b0;
            rsp_end_in   = 1'b0;
         end
         held_v_in    = 1'b1;
         held_byte_in = put_byte;
         held_cnt_in  = put_cnt;
      end else if (state_ff == abre_pkg::ST_END && end_ok && held_v_ff) begin
         rsp_v_in     = 1'b1;
         rsp_byte_in  = held_byte_ff;
         rsp_cnt_in   = held_cnt_ff;
         rsp_final_in = 1'b1;
         rsp_end_in   = last_ff;
         held_v_in    = 1'b0;
      end
   end

   // tree valid bits: cleared by reset and by flush
   always_comb begin
      prob_vld_in = prob_vld_ff;
      if (mem_we) prob_vld_in[node_ff] = 1'b1;
      if (clear_state) prob_vld_in = '0;
   end

   // tree ram, registered read
   always_ff @(posedge clock) begin
      if (mem_we) prob_mem[node_ff] <= mem_wdata;
      prob_rd_ff     <= prob_mem[node_ff];
      prob_rd_vld_ff <= prob_vld_ff[node_ff];
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= abre_pkg::ADAPT_SHIFT_RST;
      end else begin
         shift_ff <= shift_in;
      end
   end

   always_comb begin
      shift_in = shift_ff;
      if (csr_ch.valid && csr_ch.ready) shift_in = csr_ch.adapt_shift;
   end

   // control and coder state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= abre_pkg::ST_IDLE;
         low_ff      <= '0;
         range_ff    <= abre_pkg::RANGE_RST;
         pcount_ff   <= RUN_ONE;
         pbyte_ff    <= '0;
         prob_vld_ff <= '0;
         held_v_ff   <= 1'b0;
         rsp_v_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         low_ff      <= low_in;
         range_ff    <= range_in;
         pcount_ff   <= pcount_in;
         pbyte_ff    <= pbyte_in;
         prob_vld_ff <= prob_vld_in;
         held_v_ff   <= held_v_in;
         rsp_v_ff    <= rsp_v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sym_ff       <= sym_in;
      last_ff      <= last_in;
      node_ff      <= node_in;
      bit_cnt_ff   <= bit_cnt_in;
      fl_cnt_ff    <= fl_cnt_in;
      mid_ff       <= mid_in;
      held_byte_ff <= held_byte_in;
      held_cnt_ff  <= held_cnt_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_final_ff <= rsp_final_in;
      rsp_end_ff   <= rsp_end_in;
   end

endmodule
